### design/c65_pkg.sv
// shared types, opcode names and constants for the 6502 execute unit
// no dependencies; every other file but c65_ram imports this package
package c65_pkg;

	localparam int STACK_DEPTH = 256;
	localparam int STK_AW = $clog2(STACK_DEPTH);

	localparam int FL_C = 0;
	localparam int FL_Z = 1;
	localparam int FL_I = 2;
	localparam int FL_D = 3;
	localparam int FL_B = 4;
	localparam int FL_V = 6;
	localparam int FL_N = 7;

	typedef enum logic [5:0] {
		FN_ADC = 6'd0,  FN_AND = 6'd1,  FN_ASL = 6'd2,  FN_BCC = 6'd3,
		FN_BCS = 6'd4,  FN_BEQ = 6'd5,  FN_BIT = 6'd6,  FN_BMI = 6'd7,
		FN_BNE = 6'd8,  FN_BPL = 6'd9,  FN_BRK = 6'd10, FN_BVC = 6'd11,
		FN_BVS = 6'd12, FN_CLC = 6'd13, FN_CLD = 6'd14, FN_CLI = 6'd15,
		FN_CLV = 6'd16, FN_CMP = 6'd17, FN_CPX = 6'd18, FN_CPY = 6'd19,
		FN_DEC = 6'd20, FN_DEX = 6'd21, FN_DEY = 6'd22, FN_EOR = 6'd23,
		FN_INC = 6'd24, FN_INX = 6'd25, FN_INY = 6'd26, FN_JMP = 6'd27,
		FN_JSR = 6'd28, FN_LDA = 6'd29, FN_LDX = 6'd30, FN_LDY = 6'd31,
		FN_LSR = 6'd32, FN_NOP = 6'd33, FN_ORA = 6'd34, FN_PHA = 6'd35,
		FN_PHP = 6'd36, FN_PLA = 6'd37, FN_PLP = 6'd38, FN_ROL = 6'd39,
		FN_ROR = 6'd40, FN_RTI = 6'd41, FN_RTS = 6'd42, FN_SBC = 6'd43,
		FN_SEC = 6'd44, FN_SED = 6'd45, FN_SEI = 6'd46, FN_STA = 6'd47,
		FN_STX = 6'd48, FN_STY = 6'd49, FN_TAX = 6'd50, FN_TAY = 6'd51,
		FN_TSX = 6'd52, FN_TXA = 6'd53, FN_TXS = 6'd54, FN_TYA = 6'd55
	} func_e;

	typedef enum logic [1:0] {
		CL_NORM = 2'd0,
		CL_JSR  = 2'd1,
		CL_PULL = 2'd2
	} cls_e;

	typedef struct packed {
		logic [5:0]  func;
		logic [7:0]  operand;
		logic [15:0] target_address;
		logic        on_accumulator;
		logic [1:0]  instr_length;
	} in_t;

	typedef struct packed {
		logic [7:0]  acc_out;
		logic [7:0]  x_out;
		logic [7:0]  y_out;
		logic [7:0]  sp_out;
		logic [7:0]  flags_out;
		logic [15:0] pc_out;
		logic        write_enable;
		logic [7:0]  write_value;
		logic        invalid_op;
	} out_t;

	typedef struct packed {
		in_t        d;
		cls_e       cls;
		logic [1:0] npull;
	} qitem_t;

	typedef struct packed {
		logic busy;
		logic pop;
		logic ram_we;
		logic ram_re;
	} bk_stat_t;

endpackage

### design/cpu6502_execute_unit.sv
// top level of the 6502 execute unit: front end, item queue and execute back end
// depends on c65_pkg, c65_front, c65_queue, c65_back (and c65_ram below it)
//
// usage:
// - input channel in_valid / in_stall / in_data carries one decoded instruction
//   per item; an item is taken at a clock edge with in_valid high and in_stall low
// - output channel out_valid / out_stall / out_data returns one result per item,
//   the registers after the instruction plus an optional memory write byte
// - cfg_write_enable / cfg_write_data load the start address into the pc
// - an item is classified and queued (two entries), then executed from the head
// - throughput: one item per cycle for all non-stack work and for PHA/PHP while the
//   result is not stalled; JSR, PLA/PLP, RTS and RTI hold the queue head for each byte on the
//   stack ram, with one push or one pull read per cycle (registered read data)
// - reset clears A, X, Y and flags, sets SP to 0xFF and pc to zero; the stack
//   reads as zero until written through per-entry valid flops, no clearing pass
// - a stalled result holds; the queue keeps taking items until it is full,
//   then in_stall rises
module cpu6502_execute_unit import c65_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_t        out_data,
	input  logic        cfg_write_enable,
	input  logic [15:0] cfg_write_data
);

	qitem_t   cls_item;
	qitem_t   head;
	logic     q_full;
	logic     q_valid;
	bk_stat_t bk_stat;

	c65_front u_front (
		.din  (in_data),
		.dout (cls_item)
	);

	c65_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (in_valid && !q_full),
		.din    (cls_item),
		.full   (q_full),
		.pop    (bk_stat.pop),
		.valid  (q_valid),
		.dout   (head)
	);

	assign in_stall = q_full;

	c65_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write_enable (cfg_write_enable),
		.cfg_write_data   (cfg_write_data),
		.q_valid          (q_valid),
		.it               (head),
		.stat             (bk_stat),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.out_data         (out_data)
	);

	a_busy_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		bk_stat.busy |-> q_valid) else $error("sequencer busy with empty queue");

	a_pop_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		bk_stat.pop |-> q_valid) else $error("pop from empty queue");

	a_one_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(bk_stat.ram_we && bk_stat.ram_re)) else $error("stack write and read together");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_data)) else $error("result changed under stall");

endmodule

### design/c65_ram.sv
// generic single write port ram with one registered read port
// no dependencies
module c65_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### design/c65_front.sv
// front end: classifies each accepted item by how it uses the stack
// depends on c65_pkg
module c65_front import c65_pkg::*; (
	input  in_t    din,
	output qitem_t dout
);

	always_comb begin
		dout.d = din;
		dout.cls = CL_NORM;
		dout.npull = 2'd0;
		case (func_e'(din.func))
			FN_JSR: begin
				dout.cls = CL_JSR;
			end
			FN_PLA, FN_PLP: begin
				dout.cls = CL_PULL;
				dout.npull = 2'd1;
			end
			FN_RTS: begin
				dout.cls = CL_PULL;
				dout.npull = 2'd2;
			end
			FN_RTI: begin
				dout.cls = CL_PULL;
				dout.npull = 2'd3;
			end
			default: begin
				dout.cls = CL_NORM;
			end
		endcase
	end

endmodule

### design/c65_queue.sv
// two entry item queue between front end and execute back end
// depends on c65_pkg
module c65_queue import c65_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  qitem_t din,
	output logic   full,
	input  logic   pop,
	output logic   valid,
	output qitem_t dout
);

	qitem_t     ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign dout  = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= din;
		end
	end

endmodule

### design/c65_back.sv
// execute back end: architectural registers, stack sequencer and result register
// depends on c65_pkg and c65_ram
module c65_back import c65_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write_enable,
	input  logic [15:0] cfg_write_data,
	input  logic        q_valid,
	input  qitem_t      it,
	output bk_stat_t    stat,
	output logic        out_valid,
	input  logic        out_stall,
	output out_t        out_data
);

	typedef enum logic [2:0] {
		S_RUN  = 3'b001,
		S_JSR  = 3'b010,
		S_PULL = 3'b100
	} st_e;

	st_e  st_q, st_d;
	logic [7:0]  a_q, x_q, y_q, sp_q, p_q;
	logic [15:0] pc_q;
	logic [1:0]  idx_q, idx_d;
	logic [7:0]  b0_q, b1_q;
	logic [STACK_DEPTH-1:0] vld_q;
	logic        rd_vld_q;
	logic [7:0]  rd_data;
	logic [7:0]  pulled;
	logic        out_valid_q;
	out_t        out_q;
	logic        out_free;

	// normal-op results
	logic [7:0]  na, nx, ny, nsp, np;
	logic [15:0] npc;
	logic        nwe, nbad, npush;
	logic [7:0]  nwv, npv;
	logic [15:0] base_pc, offs, ret;
	logic [7:0]  opn, m, sh_res, addb;
	logic        sh_c;
	logic [8:0]  sum;

	// selected next state
	logic [7:0]  ra, rx, ry, rsp, rp;
	logic [15:0] rpc;
	logic        owe, obad, fire, pop;
	logic [7:0]  owv;
	logic        ram_we, ram_re;
	logic [STK_AW-1:0] ram_wa, ram_ra;
	logic [7:0]  ram_wd;
	logic [7:0]  sp_inc;

	function automatic logic [7:0] zn(input logic [7:0] p, input logic [7:0] v);
		logic [7:0] r;
		r = p;
		r[FL_Z] = (v == 8'd0);
		r[FL_N] = v[7];
		return r;
	endfunction

	function automatic logic [7:0] cmpf(input logic [7:0] p, input logic [7:0] rg,
			input logic [7:0] n);
		logic [8:0] d;
		logic [7:0] r;
		d = {1'b0, rg} - {1'b0, n};
		r = zn(p, d[7:0]);
		r[FL_C] = ~d[8];
		return r;
	endfunction

	function automatic logic [STK_AW-1:0] sidx(input logic [7:0] s);
		return STK_AW'(s % STACK_DEPTH);
	endfunction

	assign pulled   = rd_vld_q ? rd_data : 8'd0;
	assign out_free = !out_valid_q || !out_stall;
	assign base_pc  = pc_q + 16'(it.d.instr_length);
	assign ret      = base_pc - 16'd1;
	assign opn      = it.d.operand;
	assign offs     = {{8{opn[7]}}, opn};
	assign m        = it.d.on_accumulator ? a_q : opn;
	assign addb     = (func_e'(it.d.func) == FN_SBC) ? ~opn : opn;
	assign sum      = {1'b0, a_q} + {1'b0, addb} + {8'd0, p_q[FL_C]};
	assign sp_inc   = sp_q + 8'd1;

	always_comb begin
		case (func_e'(it.d.func))
			FN_ASL:  {sh_c, sh_res} = {m[7], m[6:0], 1'b0};
			FN_LSR:  {sh_c, sh_res} = {m[0], 1'b0, m[7:1]};
			FN_ROL:  {sh_c, sh_res} = {m[7], m[6:0], p_q[FL_C]};
			FN_ROR:  {sh_c, sh_res} = {m[0], p_q[FL_C], m[7:1]};
			default: {sh_c, sh_res} = {1'b0, m};
		endcase
	end

	always_comb begin
		na = a_q; nx = x_q; ny = y_q; nsp = sp_q; np = p_q;
		npc = base_pc;
		nwe = 1'b0; nwv = 8'd0; nbad = 1'b0; npush = 1'b0; npv = 8'd0;
		case (func_e'(it.d.func))
			FN_ADC, FN_SBC: begin
				np[FL_C] = sum[8];
				np[FL_V] = (a_q[7] ^ sum[7]) & (addb[7] ^ sum[7]);
				na = sum[7:0];
				np = zn(np, na);
			end
			FN_AND: begin na = a_q & opn; np = zn(p_q, na); end
			FN_EOR: begin na = a_q ^ opn; np = zn(p_q, na); end
			FN_ORA: begin na = a_q | opn; np = zn(p_q, na); end
			FN_ASL, FN_LSR, FN_ROL, FN_ROR: begin
				np[FL_C] = sh_c;
				np = zn(np, sh_res);
				if (it.d.on_accumulator) begin
					na = sh_res;
				end else begin
					nwe = 1'b1;
					nwv = sh_res;
				end
			end
			FN_BCC: if (!p_q[FL_C]) npc = base_pc + offs;
			FN_BCS: if (p_q[FL_C]) npc = base_pc + offs;
			FN_BEQ: if (p_q[FL_Z]) npc = base_pc + offs;
			FN_BNE: if (!p_q[FL_Z]) npc = base_pc + offs;
			FN_BMI: if (p_q[FL_N]) npc = base_pc + offs;
			FN_BPL: if (!p_q[FL_N]) npc = base_pc + offs;
			FN_BVC: if (!p_q[FL_V]) npc = base_pc + offs;
			FN_BVS: if (p_q[FL_V]) npc = base_pc + offs;
			FN_BIT: begin
				np[FL_Z] = ((a_q & opn) == 8'd0);
				np[FL_N] = opn[7];
				np[FL_V] = opn[6];
			end
			FN_BRK: np[FL_B] = 1'b1;
			FN_CLC: np[FL_C] = 1'b0;
			FN_CLD: np[FL_D] = 1'b0;
			FN_CLI: np[FL_I] = 1'b0;
			FN_CLV: np[FL_V] = 1'b0;
			FN_SEC: np[FL_C] = 1'b1;
			FN_SED: np[FL_D] = 1'b1;
			FN_SEI: np[FL_I] = 1'b1;
			FN_CMP: np = cmpf(p_q, a_q, opn);
			FN_CPX: np = cmpf(p_q, x_q, opn);
			FN_CPY: np = cmpf(p_q, y_q, opn);
			FN_DEC: begin nwe = 1'b1; nwv = opn - 8'd1; np = zn(p_q, nwv); end
			FN_INC: begin nwe = 1'b1; nwv = opn + 8'd1; np = zn(p_q, nwv); end
			FN_DEX: begin nx = x_q - 8'd1; np = zn(p_q, nx); end
			FN_DEY: begin ny = y_q - 8'd1; np = zn(p_q, ny); end
			FN_INX: begin nx = x_q + 8'd1; np = zn(p_q, nx); end
			FN_INY: begin ny = y_q + 8'd1; np = zn(p_q, ny); end
			FN_JMP: npc = it.d.target_address;
			FN_LDA: begin na = opn; np = zn(p_q, na); end
			FN_LDX: begin nx = opn; np = zn(p_q, nx); end
			FN_LDY: begin ny = opn; np = zn(p_q, ny); end
			FN_NOP: npc = base_pc;
			FN_PHA: begin npush = 1'b1; npv = a_q; nsp = sp_q - 8'd1; end
			FN_PHP: begin npush = 1'b1; npv = p_q; nsp = sp_q - 8'd1; end
			FN_STA: begin nwe = 1'b1; nwv = a_q; end
			FN_STX: begin nwe = 1'b1; nwv = x_q; end
			FN_STY: begin nwe = 1'b1; nwv = y_q; end
			FN_TAX: begin nx = a_q; np = zn(p_q, nx); end
			FN_TAY: begin ny = a_q; np = zn(p_q, ny); end
			FN_TSX: begin nx = sp_q; np = zn(p_q, nx); end
			FN_TXA: begin na = x_q; np = zn(p_q, na); end
			FN_TXS: nsp = x_q;
			FN_TYA: begin na = y_q; np = zn(p_q, na); end
			default: begin
				nbad = 1'b1;
				npc = pc_q;
			end
		endcase
	end

	// stack sequencer: one ram access per cycle
	always_comb begin
		ra = a_q; rx = x_q; ry = y_q; rsp = sp_q; rp = p_q; rpc = pc_q;
		owe = 1'b0; owv = 8'd0; obad = 1'b0;
		fire = 1'b0; pop = 1'b0;
		ram_we = 1'b0; ram_wa = sidx(sp_q); ram_wd = 8'd0;
		ram_re = 1'b0; ram_ra = sidx(sp_inc);
		st_d = st_q; idx_d = idx_q;
		case (st_q)
			S_RUN: begin
				if (q_valid) begin
					case (it.cls)
						CL_JSR: begin
							ram_we = 1'b1;
							ram_wd = ret[15:8];
							rsp = sp_q - 8'd1;
							st_d = S_JSR;
						end
						CL_PULL: begin
							ram_re = 1'b1;
							rsp = sp_inc;
							idx_d = 2'd0;
							st_d = S_PULL;
						end
						default: begin
							if (out_free) begin
								ra = na; rx = nx; ry = ny; rsp = nsp; rp = np; rpc = npc;
								owe = nwe; owv = nwv; obad = nbad;
								ram_we = npush;
								ram_wd = npv;
								fire = 1'b1;
								pop = 1'b1;
							end
						end
					endcase
				end
			end
			S_JSR: begin
				if (out_free) begin
					ram_we = 1'b1;
					ram_wd = ret[7:0];
					rsp = sp_q - 8'd1;
					rpc = it.d.target_address;
					fire = 1'b1;
					pop = 1'b1;
					st_d = S_RUN;
				end
			end
			S_PULL: begin
				if (idx_q != it.npull - 2'd1) begin
					ram_re = 1'b1;
					rsp = sp_inc;
					idx_d = idx_q + 2'd1;
				end else if (out_free) begin
					rpc = base_pc;
					case (func_e'(it.d.func))
						FN_PLA: begin ra = pulled; rp = zn(p_q, pulled); end
						FN_PLP: rp = pulled;
						FN_RTS: rpc = {pulled, b0_q} + 16'd1;
						FN_RTI: begin rp = b0_q; rpc = {pulled, b1_q}; end
						default: rpc = base_pc;
					endcase
					fire = 1'b1;
					pop = 1'b1;
					st_d = S_RUN;
				end
			end
			default: st_d = S_RUN;
		endcase
	end

	c65_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_wa),
		.wdata (ram_wd),
		.re    (ram_re),
		.raddr (ram_ra),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_RUN;
			idx_q       <= 2'd0;
			a_q         <= 8'd0;
			x_q         <= 8'd0;
			y_q         <= 8'd0;
			sp_q        <= 8'hFF;
			p_q         <= 8'd0;
			pc_q        <= 16'd0;
			vld_q       <= '0;
			rd_vld_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q  <= st_d;
			idx_q <= idx_d;
			a_q   <= ra;
			x_q   <= rx;
			y_q   <= ry;
			sp_q  <= rsp;
			p_q   <= rp;
			pc_q  <= cfg_write_enable ? cfg_write_data : rpc;
			if (ram_we) begin
				vld_q[ram_wa] <= 1'b1;
			end
			if (ram_re) begin
				rd_vld_q <= vld_q[ram_ra];
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// stash the early bytes of multi-byte pulls, and register the result when it fires
	always_ff @(posedge clk) begin
		if (st_q == S_PULL && idx_d != idx_q) begin
			if (idx_q == 2'd0) begin
				b0_q <= pulled;
			end else begin
				b1_q <= pulled;
			end
		end
		if (fire) begin
			out_q.acc_out      <= ra;
			out_q.x_out        <= rx;
			out_q.y_out        <= ry;
			out_q.sp_out       <= rsp;
			out_q.flags_out    <= rp;
			out_q.pc_out       <= rpc;
			out_q.write_enable <= owe;
			out_q.write_value  <= owv;
			out_q.invalid_op   <= obad;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_data    = out_q;
	assign stat.busy   = (st_q != S_RUN);
	assign stat.pop    = pop;
	assign stat.ram_we = ram_we;
	assign stat.ram_re = ram_re;

endmodule

### dv/cpu6502_execute_unit_checker.sv
// result checker for the 6502 execute unit: watches both channels, predicts each result
// depends on c65_pkg for the payload structs and opcode names
`timescale 1ns / 1ps
module cpu6502_execute_unit_checker import c65_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  in_t         in_data,
	input  logic        out_valid,
	input  logic        out_stall,
	input  out_t        out_data,
	input  logic        cfg_write_enable,
	input  logic [15:0] cfg_write_data,
	output int          fail_count,
	output int          pending,
	output int          results_seen
);

	logic [7:0]  cpu_a, cpu_x, cpu_y, cpu_sp, cpu_p;
	logic [15:0] cpu_pc;
	logic [7:0]  stack_mem [STACK_DEPTH];
	out_t        expected_results [$];

	function automatic logic [7:0] zn(logic [7:0] v);
		cpu_p[FL_Z] = (v == 8'd0);
		cpu_p[FL_N] = v[7];
		return v;
	endfunction

	task automatic push_byte(logic [7:0] v);
		stack_mem[cpu_sp] = v;
		cpu_sp = cpu_sp - 8'd1;
	endtask

	function automatic logic [7:0] pull_byte();
		cpu_sp = cpu_sp + 8'd1;
		return stack_mem[cpu_sp];
	endfunction

	task automatic add_carry(logic [7:0] n);
		logic [8:0] sum;
		logic [7:0] r;
		sum = {1'b0, cpu_a} + {1'b0, n} + {8'd0, cpu_p[FL_C]};
		r = sum[7:0];
		cpu_p[FL_C] = sum[8];
		cpu_p[FL_V] = ((cpu_a ^ r) & (n ^ r) & 8'h80) != 0;
		cpu_a = zn(r);
	endtask

	task automatic compare(logic [7:0] r, logic [7:0] n);
		cpu_p[FL_C] = (r >= n);
		void'(zn(r - n));
	endtask

	task automatic execute(in_t d);
		out_t        res;
		logic [15:0] npc, ret;
		logic [7:0]  m, lo, hi, n;
		logic        c, we, bad, taken;
		func_e       f;
		n = d.operand;
		npc = cpu_pc + {14'd0, d.instr_length};
		we = 0; bad = 0; taken = 0;
		res.write_value = 8'd0;
		f = func_e'(d.func);
		if (d.func > 6'd55) bad = 1;
		else case (f)
			FN_ADC: add_carry(n);
			FN_SBC: add_carry(~n);
			FN_AND: cpu_a = zn(cpu_a & n);
			FN_EOR: cpu_a = zn(cpu_a ^ n);
			FN_ORA: cpu_a = zn(cpu_a | n);
			FN_ASL, FN_LSR, FN_ROL, FN_ROR: begin
				m = d.on_accumulator ? cpu_a : n;
				c = cpu_p[FL_C];
				case (f)
					FN_ASL: begin cpu_p[FL_C] = m[7]; m = m << 1; end
					FN_LSR: begin cpu_p[FL_C] = m[0]; m = m >> 1; end
					FN_ROL: begin cpu_p[FL_C] = m[7]; m = {m[6:0], c}; end
					default: begin cpu_p[FL_C] = m[0]; m = {c, m[7:1]}; end
				endcase
				m = zn(m);
				if (d.on_accumulator) cpu_a = m;
				else begin
					we = 1; res.write_value = m;
				end
			end
			FN_BCC: taken = !cpu_p[FL_C];
			FN_BCS: taken = cpu_p[FL_C];
			FN_BEQ: taken = cpu_p[FL_Z];
			FN_BNE: taken = !cpu_p[FL_Z];
			FN_BMI: taken = cpu_p[FL_N];
			FN_BPL: taken = !cpu_p[FL_N];
			FN_BVC: taken = !cpu_p[FL_V];
			FN_BVS: taken = cpu_p[FL_V];
			FN_BIT: begin
				cpu_p[FL_Z] = (cpu_a & n) == 0;
				cpu_p[FL_N] = n[7];
				cpu_p[FL_V] = n[6];
			end
			FN_BRK: cpu_p[FL_B] = 1;
			FN_CLC: cpu_p[FL_C] = 0;
			FN_CLD: cpu_p[FL_D] = 0;
			FN_CLI: cpu_p[FL_I] = 0;
			FN_CLV: cpu_p[FL_V] = 0;
			FN_SEC: cpu_p[FL_C] = 1;
			FN_SED: cpu_p[FL_D] = 1;
			FN_SEI: cpu_p[FL_I] = 1;
			FN_CMP: compare(cpu_a, n);
			FN_CPX: compare(cpu_x, n);
			FN_CPY: compare(cpu_y, n);
			FN_DEC: begin we = 1; res.write_value = zn(n - 8'd1); end
			FN_INC: begin we = 1; res.write_value = zn(n + 8'd1); end
			FN_DEX: cpu_x = zn(cpu_x - 8'd1);
			FN_DEY: cpu_y = zn(cpu_y - 8'd1);
			FN_INX: cpu_x = zn(cpu_x + 8'd1);
			FN_INY: cpu_y = zn(cpu_y + 8'd1);
			FN_JMP: npc = d.target_address;
			FN_JSR: begin
				ret = npc - 16'd1;
				push_byte(ret[15:8]);
				push_byte(ret[7:0]);
				npc = d.target_address;
			end
			FN_LDA: cpu_a = zn(n);
			FN_LDX: cpu_x = zn(n);
			FN_LDY: cpu_y = zn(n);
			FN_NOP: ;
			FN_PHA: push_byte(cpu_a);
			FN_PHP: push_byte(cpu_p);
			FN_PLA: cpu_a = zn(pull_byte());
			FN_PLP: cpu_p = pull_byte();
			FN_RTI: begin
				cpu_p = pull_byte();
				lo = pull_byte();
				hi = pull_byte();
				npc = {hi, lo};
			end
			FN_RTS: begin
				lo = pull_byte();
				hi = pull_byte();
				npc = {hi, lo} + 16'd1;
			end
			FN_STA: begin we = 1; res.write_value = cpu_a; end
			FN_STX: begin we = 1; res.write_value = cpu_x; end
			FN_STY: begin we = 1; res.write_value = cpu_y; end
			FN_TAX: cpu_x = zn(cpu_a);
			FN_TAY: cpu_y = zn(cpu_a);
			FN_TSX: cpu_x = zn(cpu_sp);
			FN_TXA: cpu_a = zn(cpu_x);
			FN_TXS: cpu_sp = cpu_x;
			FN_TYA: cpu_a = zn(cpu_y);
			default: bad = 1;
		endcase
		// branch offset is a signed byte
		if (taken) npc = npc + {{8{n[7]}}, n};
		if (!bad) cpu_pc = npc;
		res.acc_out = cpu_a;
		res.x_out = cpu_x;
		res.y_out = cpu_y;
		res.sp_out = cpu_sp;
		res.flags_out = cpu_p;
		res.pc_out = cpu_pc;
		res.write_enable = we;
		res.invalid_op = bad;
		expected_results.push_back(res);
	endtask

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			cpu_a = 0; cpu_x = 0; cpu_y = 0; cpu_p = 0; cpu_sp = 8'hff; cpu_pc = 0;
			foreach (stack_mem[i]) stack_mem[i] = 8'd0;
			expected_results.delete();
			fail_count = 0;
			results_seen = 0;
			pending = 0;
		end else begin
			// the result leaving now was predicted before the item arriving now
			if (out_valid && !out_stall) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					$error("result with no item outstanding");
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("acc_out", want.acc_out, out_data.acc_out);
					check_field("x_out", want.x_out, out_data.x_out);
					check_field("y_out", want.y_out, out_data.y_out);
					check_field("sp_out", want.sp_out, out_data.sp_out);
					check_field("flags_out", want.flags_out, out_data.flags_out);
					check_field("pc_out", want.pc_out, out_data.pc_out);
					check_field("write_enable", want.write_enable, out_data.write_enable);
					check_field("write_value", want.write_value, out_data.write_value);
					check_field("invalid_op", want.invalid_op, out_data.invalid_op);
				end
			end
			if (in_valid && !in_stall) execute(in_data);
			if (cfg_write_enable) cpu_pc = cfg_write_data;
			pending = expected_results.size();
		end
	end

endmodule

### dv/testbench.sv
// stimulus and verdict for the 6502 execute unit
// depends on c65_pkg, cpu6502_execute_unit and cpu6502_execute_unit_checker
`timescale 1ns / 1ps
module testbench;
	import c65_pkg::*;

	localparam int RUN_LIMIT = 200000;
	localparam int IN_W = $bits(in_t);

	logic        clk, arst_n;
	logic        in_valid, in_stall, out_valid, out_stall;
	in_t         in_data;
	out_t        out_data;
	logic        cfg_write_enable;
	logic [15:0] cfg_write_data;
	int          fail_count, pending, results_seen;
	int          cycle_count, item_count;
	logic        hold_off;

	cpu6502_execute_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_write_enable(cfg_write_enable), .cfg_write_data(cfg_write_data)
	);

	cpu6502_execute_unit_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_write_enable(cfg_write_enable), .cfg_write_data(cfg_write_data),
		.fail_count(fail_count), .pending(pending), .results_seen(results_seen)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > RUN_LIMIT) begin
				$display("timeout after %0d cycles", cycle_count);
				$display("FAIL");
				$finish;
			end
		end
	end

	// receiver: random stall per item, plus a long hold-off while requested
	initial begin
		int gap;
		out_stall = 1;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_stall <= 1;
				repeat (40) @(negedge clk);
			end
			gap = $urandom_range(0, 6);
			if ($urandom_range(0, 3) == 0) gap = 0;
			if (gap > 0) begin
				out_stall <= 1;
				repeat (gap - 1) @(negedge clk);
				@(negedge clk);
			end
			out_stall <= 0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	task automatic send_item(in_t d, bit no_gap);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		in_data <= d;
		in_valid <= 1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		item_count++;
	endtask

	task automatic send_op(func_e f, logic [7:0] n, logic [15:0] tgt, logic acc, logic [1:0] len);
		in_t d;
		d.func = f; d.operand = n; d.target_address = tgt;
		d.on_accumulator = acc; d.instr_length = len;
		send_item(d, 0);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_start(logic [15:0] v);
		cfg_write_enable <= 1;
		cfg_write_data <= v;
		@(negedge clk);
		cfg_write_enable <= 0;
	endtask

	function automatic in_t random_item();
		in_t d;
		d = in_t'(IN_W'({$urandom, $urandom}));
		if ($urandom_range(0, 9) != 0) d.func = 6'($urandom_range(0, 55));
		if ($urandom_range(0, 9) != 0) d.instr_length = 2'($urandom_range(1, 3));
		return d;
	endfunction

	// well-formed stack sequences with random content
	task automatic stack_sequence();
		case ($urandom_range(0, 3))
			0: begin
				send_op(FN_JSR, 8'($urandom), 16'($urandom), 0, 3);
				repeat ($urandom_range(0, 4)) send_item(random_item(), 0);
				send_op(FN_RTS, 8'($urandom), 16'($urandom), 0, 1);
			end
			1: begin
				send_op(FN_LDA, 8'($urandom), 0, 0, 2);
				send_op(FN_PHA, 0, 0, 0, 1);
				send_op(FN_LDA, 8'($urandom), 0, 0, 2);
				send_op(FN_PLA, 0, 0, 0, 1);
			end
			2: begin
				send_op(FN_JSR, 8'($urandom), 16'($urandom), 0, 3);
				send_op(FN_PHP, 0, 0, 0, 1);
				send_op(FN_RTI, 0, 0, 0, 1);
			end
			default: begin
				send_op(FN_PHP, 0, 0, 0, 1);
				send_op(FN_PLP, 0, 0, 0, 1);
				send_op(FN_TSX, 0, 0, 0, 1);
				send_op(FN_TXS, 0, 0, 0, 1);
			end
		endcase
	endtask

	initial begin
		in_t d;
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		cfg_write_enable = 0;
		cfg_write_data = 0;
		hold_off = 0;
		item_count = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		write_start(16'hffff);
		// directed: every code but 56 to 61, extremes of the fields
		for (int f = 0; f < 64; f++) begin
			d.func = 6'(f);
			d.operand = (f % 2) ? 8'hff : 8'h80;
			d.target_address = (f % 3) ? 16'hffff : 16'h0000;
			d.on_accumulator = f[2];
			d.instr_length = f[1:0];
			if (f >= 56 && f < 62) continue;
			send_item(d, 0);
		end
		send_op(FN_ADC, 8'h7f, 0, 0, 2);
		send_op(FN_SBC, 8'h00, 0, 0, 2);
		send_op(FN_CMP, 8'h00, 0, 0, 2);
		send_op(FN_ROR, 8'h01, 0, 1, 1);
		send_op(FN_BNE, 8'h7f, 0, 0, 2);
		drain();

		write_start(16'h0000);
		for (int i = 0; i < 150; i++) begin
			if (i == 50) begin
				// long receiver hold-off while the sender keeps going
				hold_off <= 1;
				for (int k = 0; k < 16; k++) send_item(random_item(), 1);
				hold_off <= 0;
			end
			if (i == 100) drain();
			if ($urandom_range(0, 3) == 0) stack_sequence();
			else send_item(random_item(), 0);
		end
		drain();

		write_start(16'h8000);
		for (int i = 0; i < 120; i++) begin
			if ($urandom_range(0, 2) == 0) stack_sequence();
			else send_item(random_item(), $urandom_range(0, 3) == 0);
		end
		drain();

		$display("sent %0d items, checked %0d results over three start addresses",
			item_count, results_seen);
		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

### sim.f
design/c65_pkg.sv
design/c65_ram.sv
design/c65_front.sv
design/c65_queue.sv
design/c65_back.sv
design/cpu6502_execute_unit.sv
dv/cpu6502_execute_unit_checker.sv
dv/testbench.sv
